@@ rtl/nearest_point_search_assert.svh @@
// ----------------------------------------------------------------------------
// nearest point search assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_ASSERT_SVH
`define NEAREST_POINT_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// expression holds at every edge out of reset
`define NPS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define NPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define NPS_ASSERT_ALWAYS(lbl, expr, msg)
`define NPS_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg
// word types, operation codes and status codes of the nearest point search
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int FIELD_BITS = 24;
    localparam int IDX_BITS   = 10;
    localparam int DIST_BITS  = 48;

    // operation codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_QUERY_DONE = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;
    localparam logic [1:0] STATUS_DONE       = 2'd3;

    localparam logic [DIST_BITS-1:0] DIST_SAT = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [FIELD_BITS-1:0] coord_x;
        logic signed [FIELD_BITS-1:0] coord_y;
        logic signed [FIELD_BITS-1:0] coord_z;
    } t_nps_in;

    typedef struct packed {
        logic [IDX_BITS-1:0]  nearest_index;
        logic [DIST_BITS-1:0] nearest_distance;
        logic [1:0]           status;
    } t_nps_out;

    // control that travels alongside a point through the distance pipe
    typedef struct packed {
        logic valid;
        logic last;
    } t_nps_tag;

endpackage

@@ rtl/nps_point_ram.sv @@
// ----------------------------------------------------------------------------
// nps_point_ram
// point table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nps_point_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 72,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/nps_dist_pipe.sv @@
// ----------------------------------------------------------------------------
// nps_dist_pipe
// three-stage squared distance pipe: abs difference, squares, saturating sum
// ----------------------------------------------------------------------------
module nps_dist_pipe #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 10,
    parameter int DISTW      = 52
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nps_pkg::t_nps_tag         i_tag,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic [3*COORD_BITS-1:0]   i_query,
    input  logic [3*COORD_BITS-1:0]   i_point,
    output nps_pkg::t_nps_tag         o_tag,
    output logic [IDX_W-1:0]          o_idx,
    output logic [DISTW-1:0]          o_dist
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int MW   = (DW > 32) ? 32 : DW;
    localparam int SW   = 2 * MW;
    localparam int SUMW = SW + 2;

    localparam logic [DW-1:0]   SQ_LIM  = DW'({MW{1'b1}});
    localparam logic [SUMW-1:0] SUM_CAP = SUMW'({DISTW{1'b1}});

    nps_pkg::t_nps_tag r_tag1, r_tag2, r_tag3;
    logic [IDX_W-1:0]  r_idx1, r_idx2, r_idx3;
    logic [DW-1:0]     r_ad [3];
    logic [SW-1:0]     r_sq [3];
    logic [DISTW-1:0]  r_dist;
    logic [SUMW-1:0]   sum;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [CB-1:0] q_c, p_c;
        logic signed [DW-1:0] df;
        logic [DW-1:0]        ad;
        logic [SW-1:0]        prod;
        logic                 sq_sat;

        assign q_c = $signed(i_query[k*CB +: CB]);
        assign p_c = $signed(i_point[k*CB +: CB]);
        assign df  = DW'(q_c) - DW'(p_c);
        assign ad  = df[DW-1] ? DW'(-df) : DW'(df);

        // magnitude beyond 32 bits saturates the square
        assign sq_sat = r_ad[k] > SQ_LIM;
        assign prod   = SW'(r_ad[k][MW-1:0]) * SW'(r_ad[k][MW-1:0]);

        always_ff @(posedge i_clk) begin
            r_ad[k] <= ad;
            r_sq[k] <= sq_sat ? {SW{1'b1}} : prod;
        end
    end

    assign sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        r_dist <= (sum > SUM_CAP) ? SUM_CAP[DISTW-1:0] : sum[DISTW-1:0];
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_tag  = r_tag3;
    assign o_idx  = r_idx3;
    assign o_dist = r_dist;

endmodule

@@ rtl/nearest_point_search.sv @@
// ----------------------------------------------------------------------------
// nearest_point_search
// brute force 3d nearest neighbor over a table of loaded points
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | word
//  --------+--------------+--------------+---------------------------------
//  in      | i_in_valid   | o_in_stall   | i_in_word  (func, coord x/y/z)
//  out     | o_out_valid  | i_out_stall  | o_out_word (index, dist, status)
//
//  clear and load are finished in the controller; a query reads the table
//  one point per cycle from the single memory read port and passes each point
//  through the distance pipe before its result is ready
//  synchronous active-low reset empties the table at once (count only)
//  one finished word can wait in the output register while the next word is
//  taken; a second finished word stalls the input until the output drains
// ----------------------------------------------------------------------------
`include "nearest_point_search_assert.svh"

module nearest_point_search #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nps_pkg::t_nps_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nps_pkg::t_nps_out o_out_word
);

    // table addressing
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    // distance widths, same derivation as the distance pipe
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int MW   = (DW > 32) ? 32 : DW;
    localparam int SUMW = 2 * MW + 2;
    localparam int DISTW = (SUMW > 64) ? 64 : SUMW;
    // widths for masking the index and clamping the distance to the fields
    localparam int IXW  = (AW > nps_pkg::IDX_BITS) ? AW : nps_pkg::IDX_BITS;
    localparam int RW   = (DISTW > nps_pkg::DIST_BITS) ? DISTW : nps_pkg::DIST_BITS;
    localparam int XB   = 32;

    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_POINTS);
    localparam logic [RW-1:0] DIST_CAP   = RW'(nps_pkg::DIST_SAT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_addr;
    logic [3*CB-1:0]    r_query;
    nps_pkg::t_nps_tag  r_rd_tag;
    logic [AW-1:0]      r_rd_idx;
    logic [AW-1:0]      r_best_i;
    logic [DISTW-1:0]   r_best_d;
    nps_pkg::t_nps_out  r_res;
    logic               r_res_pend;
    nps_pkg::t_nps_out  r_out;
    logic               r_out_valid;

    logic               in_acc;
    logic               full;
    logic               scan_last;
    logic [XB-1:0]      ext_x, ext_y, ext_z;
    logic [3*CB-1:0]    in_point;
    logic               mem_we;
    logic               mem_re;
    logic [3*CB-1:0]    mem_rdata;
    nps_pkg::t_nps_tag  pipe_tag;
    logic [AW-1:0]      pipe_idx;
    logic [DISTW-1:0]   pipe_dist;
    logic               n_take;
    logic [AW-1:0]      n_best_i;
    logic [DISTW-1:0]   n_best_d;
    logic [IXW-1:0]     load_ix_ext;
    logic [IXW-1:0]     best_ix_ext;
    logic [RW-1:0]      best_d_ext;

    // only one word in flight and room needed for its result
    assign o_in_stall = (r_state != ST_IDLE) || r_res_pend;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_count == COUNT_FULL);

    // coordinates keep their low COORD_BITS bits, sign taken from the top one
    assign ext_x    = XB'(i_in_word.coord_x);
    assign ext_y    = XB'(i_in_word.coord_y);
    assign ext_z    = XB'(i_in_word.coord_z);
    assign in_point = {ext_z[CB-1:0], ext_y[CB-1:0], ext_x[CB-1:0]};

    // loads append at the current count
    assign mem_we = in_acc && (i_in_word.func == nps_pkg::FUNC_LOAD) && !full;
    assign mem_re = (r_state == ST_SCAN);
    assign scan_last = (CW'(r_addr + CW'(1)) == r_count);

    nps_point_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (3 * CB),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_point),
        .i_re    (mem_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    nps_dist_pipe #(
        .COORD_BITS (CB),
        .IDX_W      (AW),
        .DISTW      (DISTW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_query (r_query),
        .i_point (mem_rdata),
        .o_tag   (pipe_tag),
        .o_idx   (pipe_idx),
        .o_dist  (pipe_dist)
    );

    // strict compare: the first point always wins, later ones only if closer,
    // so a tie keeps the lower index
    assign n_take   = (pipe_idx == '0) || (pipe_dist < r_best_d);
    assign n_best_i = n_take ? pipe_idx  : r_best_i;
    assign n_best_d = n_take ? pipe_dist : r_best_d;

    assign load_ix_ext = IXW'(r_count[AW-1:0]);
    assign best_ix_ext = IXW'(n_best_i);
    assign best_d_ext  = RW'(n_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_tag    <= '0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // read tag lines up with the registered memory data
            r_rd_tag.valid <= mem_re;
            r_rd_tag.last  <= mem_re && scan_last;
            r_rd_idx       <= r_addr[AW-1:0];

            if (pipe_tag.valid) begin
                r_best_i <= n_best_i;
                r_best_d <= n_best_d;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_word.func)
                            nps_pkg::FUNC_CLEAR: begin
                                r_count    <= '0;
                                r_res      <= '{'0, '0, nps_pkg::STATUS_DONE};
                                r_res_pend <= 1'b1;
                            end
                            nps_pkg::FUNC_LOAD: begin
                                if (full) begin
                                    r_res <= '{'0, '0, nps_pkg::STATUS_FULL};
                                end else begin
                                    r_count <= CW'(r_count + CW'(1));
                                    r_res   <= '{load_ix_ext[nps_pkg::IDX_BITS-1:0], '0,
                                                 nps_pkg::STATUS_DONE};
                                end
                                r_res_pend <= 1'b1;
                            end
                            nps_pkg::FUNC_QUERY: begin
                                if (r_count == '0) begin
                                    r_res      <= '{'0, '0, nps_pkg::STATUS_EMPTY};
                                    r_res_pend <= 1'b1;
                                end else begin
                                    r_query <= in_point;
                                    r_addr  <= '0;
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: begin
                                // unused code: dropped without a result
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_addr <= CW'(r_addr + CW'(1));
                    if (scan_last) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (pipe_tag.valid && pipe_tag.last) begin
                        r_res.nearest_index    <= best_ix_ext[nps_pkg::IDX_BITS-1:0];
                        r_res.nearest_distance <= (best_d_ext > DIST_CAP) ?
                            nps_pkg::DIST_SAT : best_d_ext[nps_pkg::DIST_BITS-1:0];
                        r_res.status           <= nps_pkg::STATUS_QUERY_DONE;
                        r_res_pend             <= 1'b1;
                        r_state                <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // move a finished result into the output register when it frees up
            if (r_res_pend && (!r_out_valid || !i_out_stall)) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
                r_res_pend  <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    `NPS_ASSERT_ALWAYS(a_count_bound, r_count <= COUNT_FULL, "point count above table size")
    `NPS_ASSERT_IMPLY(a_busy_stall, r_state != ST_IDLE, o_in_stall, "input taken while busy")
    `NPS_ASSERT_IMPLY(a_pipe_busy, pipe_tag.valid, r_state != ST_IDLE, "distance out of a scan")
    `NPS_ASSERT_IMPLY(a_scan_addr, r_state == ST_SCAN, r_addr < r_count, "scan past last point")

endmodule
